/* hdl/wfba_pkg.sv */
// types, constants and control bundles for the worst-fit block allocator
package wfba_pkg;

	localparam int NUM_BLOCKS = 32;
	localparam int SIZE_WIDTH = 16;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = 6;

	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(NUM_BLOCKS);
	localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(NUM_BLOCKS);

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	// one input item
	typedef struct packed {
		logic                  mode;
		logic [4:0]            block_index;
		logic [15:0]           amount;
	} req_t;

	// one result item
	typedef struct packed {
		logic                  allocated;
		logic [4:0]            chosen_block;
		logic [15:0]           chosen_block_size;
		logic [15:0]           leftover;
	} result_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic                  load_wr;
		logic                  alloc_start;
		logic                  rd_en;
		logic [IDX_W-1:0]      rd_idx;
		logic                  commit;
	} cmd_t;

endpackage

/* hdl/wfba_ctrl.sv */
// controller: accepts items, holds block_count and sequences the partition scan
module wfba_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    mode,
	input  logic                    cfg_valid,
	input  logic [5:0]              cfg_data,
	output logic                    cfg_ready,
	output logic                    busy,
	output wfba_pkg::cmd_t          cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]                        state_q;
	logic [wfba_pkg::CNT_W-1:0]        count_q;
	logic [wfba_pkg::CNT_W-1:0]        limit;
	logic [wfba_pkg::IDX_W-1:0]        scan_q;
	logic                              accept;
	logic                              last_rd;

	// saturate the search length to the table depth
	assign limit   = (count_q > wfba_pkg::COUNT_MAX) ? wfba_pkg::COUNT_MAX : count_q;
	assign accept  = start && (state_q == ST_IDLE);
	assign last_rd = (wfba_pkg::CNT_W'(scan_q) == limit - wfba_pkg::CNT_W'(1));

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// block_count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= wfba_pkg::COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// state machine and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
					if (accept && (mode == wfba_pkg::MODE_ALLOC)) begin
						state_q <= (limit == '0) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + wfba_pkg::IDX_W'(1);
					if (last_rd) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// commands to the datapath
	always_comb begin
		cmd.load_wr     = accept && (mode == wfba_pkg::MODE_LOAD);
		cmd.alloc_start = accept && (mode == wfba_pkg::MODE_ALLOC);
		cmd.rd_en       = (state_q == ST_SCAN);
		cmd.rd_idx      = scan_q;
		cmd.commit      = (state_q == ST_FIN);
	end

endmodule

/* hdl/wfba_datapath.sv */
// datapath: partition table, used marks, worst-fit tracking and result register
module wfba_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wfba_pkg::cmd_t          cmd,
	input  wfba_pkg::req_t          req,
	output wfba_pkg::result_t       result,
	output logic                    done
);

	logic [wfba_pkg::SIZE_WIDTH-1:0]   sizes_q [wfba_pkg::NUM_BLOCKS];
	logic [wfba_pkg::NUM_BLOCKS-1:0]   used_q;
	logic [wfba_pkg::SIZE_WIDTH-1:0]   amount_q;
	logic [wfba_pkg::SIZE_WIDTH-1:0]   size_s1;
	logic                              used_s1;
	logic [wfba_pkg::IDX_W-1:0]        idx_s1;
	logic                              vld_s1;
	logic                              found_q;
	logic [wfba_pkg::IDX_W-1:0]        best_idx_q;
	logic [wfba_pkg::SIZE_WIDTH-1:0]   best_size_q;
	logic [wfba_pkg::SIZE_WIDTH-1:0]   best_left_q;
	logic [wfba_pkg::SIZE_WIDTH-1:0]   left;
	logic                              fits;
	logic                              better;
	wfba_pkg::result_t                 result_q;
	logic                              done_q;

	// partition size table: write on load, registered read during the scan
	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			sizes_q[req.block_index] <= req.amount;
		end
		if (cmd.rd_en) begin
			size_s1 <= sizes_q[cmd.rd_idx];
			used_s1 <= used_q[cmd.rd_idx];
			idx_s1  <= cmd.rd_idx;
		end
	end

	// used marks: cleared by load, set when a partition is given out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (cmd.load_wr) begin
				used_q[req.block_index] <= 1'b0;
			end
			if (cmd.commit && found_q) begin
				used_q[best_idx_q] <= 1'b1;
			end
		end
	end

	// read-valid pipeline bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
		end
	end

	// fit check and worst-fit compare, lowest index wins a tie
	assign left   = size_s1 - amount_q;
	assign fits   = vld_s1 && !used_s1 && (size_s1 >= amount_q);
	assign better = fits && (!found_q || (left > best_left_q));

	// best candidate tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.alloc_start) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc_start) begin
			amount_q <= req.amount;
		end
		if (better) begin
			best_idx_q  <= idx_s1;
			best_size_q <= size_s1;
			best_left_q <= left;
		end
	end

	// result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.allocated         <= found_q;
			result_q.chosen_block      <= found_q ? best_idx_q : '0;
			result_q.chosen_block_size <= found_q ? best_size_q : '0;
			result_q.leftover          <= found_q ? best_left_q : '0;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

/* hdl/worst_fit_block_allocator.sv */
// top level of the worst-fit block allocator
//
//  channel   signals                      transfer when
//  -------   --------------------------   ---------------------------
//  item      start, busy, req             start high and busy low
//  result    done, result                 done high (one cycle)
//  config    cfg_valid, cfg_ready,        cfg_valid and cfg_ready high
//            cfg_data
//
// a load gives no result; busy stays low
// an allocate scans block_count partitions (at most 32) one per cycle through the
// table's registered read port, or none when block_count is zero; the result strobe
// follows in the cycle after the last busy cycle
// reset clears the used marks and sets block_count to 32; sizes are unset until loaded
// the result is held until the next allocate's strobe; the receiver cannot stall it
module worst_fit_block_allocator (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  wfba_pkg::req_t          req,
	output logic                    done,
	output wfba_pkg::result_t       result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [5:0]              cfg_data
);

	wfba_pkg::cmd_t cmd;

	// controller
	wfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (req.mode),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.busy      (busy),
		.cmd       (cmd)
	);

	// datapath
	wfba_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.result (result),
		.done   (done)
	);

endmodule

/* tb/worst_fit_block_allocator_tb.sv */
// testbench for the worst-fit block allocator: directed and random traffic checked by a predictor
module worst_fit_block_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 265;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	wfba_pkg::req_t     req       = '0;
	logic               cfg_valid = 1'b0;
	logic [5:0]         cfg_data  = '0;
	logic               busy;
	logic               done;
	wfba_pkg::result_t  result;
	logic               cfg_ready;

	// predictor state
	logic [15:0]        part_size [wfba_pkg::NUM_BLOCKS];
	bit                 part_used [wfba_pkg::NUM_BLOCKS];
	logic [5:0]         search_count = wfba_pkg::COUNT_RESET;
	wfba_pkg::result_t  pending_grants [$];

	int          fail_count = 0;
	int          idle_cycles = 0;
	bit          idle_on = 1'b1;

	worst_fit_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		foreach (part_used[k]) part_used[k] = 1'b0;
		foreach (part_size[k]) part_size[k] = '0;
	end

	// worst-fit search over the active partitions, marks the winner used
	function automatic wfba_pkg::result_t worst_fit_pick(input logic [15:0] want);
		wfba_pkg::result_t r;
		int          lim;
		int          best;
		bit          found;
		logic [15:0] best_left;
		logic [15:0] left;
		r         = '0;
		best      = 0;
		found     = 1'b0;
		best_left = '0;
		lim = (search_count > wfba_pkg::NUM_BLOCKS) ? wfba_pkg::NUM_BLOCKS : int'(search_count);
		for (int k = 0; k < lim; k++) begin
			if (!part_used[k] && part_size[k] >= want) begin
				left = part_size[k] - want;
				if (!found || left > best_left) begin
					found     = 1'b1;
					best_left = left;
					best      = k;
				end
			end
		end
		if (found) begin
			part_used[best]     = 1'b1;
			r.allocated         = 1'b1;
			r.chosen_block      = 5'(best);
			r.chosen_block_size = part_size[best];
			r.leftover          = best_left;
		end
		return r;
	endfunction

	function automatic wfba_pkg::req_t mk(input logic m, input logic [4:0] idx,
		input logic [15:0] amt);
		wfba_pkg::req_t it;
		it.mode        = m;
		it.block_index = idx;
		it.amount      = amt;
		return it;
	endfunction

	// update the predictor for an accepted item
	task automatic record_item(input wfba_pkg::req_t it);
		if (it.mode == wfba_pkg::MODE_LOAD) begin
			part_size[it.block_index] = it.amount;
			part_used[it.block_index] = 1'b0;
		end else begin
			pending_grants.push_back(worst_fit_pick(it.amount));
		end
	endtask

	// one item transfer, with a random lead-in gap when idle_on is set
	task automatic send_item(input wfba_pkg::req_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= it;
		do @(posedge clk); while (busy);
		record_item(it);
	endtask

	// register write while the block is idle
	task automatic write_count(input logic [5:0] value);
		start <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		search_count  = value;
	endtask

	// two partitions: tie goes to the lower index, no fit, reload frees a partition
	task automatic test_tie_and_reload();
		write_count(6'd2);
		send_item(mk(wfba_pkg::MODE_LOAD, 5'd0, 16'd100));
		send_item(mk(wfba_pkg::MODE_LOAD, 5'd1, 16'd100));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd31, 16'd50));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'd50));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'd1));
		send_item(mk(wfba_pkg::MODE_LOAD, 5'd0, 16'hFFFF));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'd0));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'hFFFF));
		send_item(mk(wfba_pkg::MODE_LOAD, 5'd1, 16'hFFFF));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'hFFFF));
	endtask

	// zero block count never allocates
	task automatic test_zero_count();
		write_count(6'd0);
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'd0));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd31, 16'hFFFF));
	endtask

	// single partition of size zero
	task automatic test_single_partition();
		write_count(6'd1);
		send_item(mk(wfba_pkg::MODE_LOAD, 5'd0, 16'd0));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'd0));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'd0));
	endtask

	// fill the whole table with a count above the table size
	task automatic test_full_table_saturated();
		logic [15:0] sz;
		write_count(6'd63);
		for (int k = 0; k < wfba_pkg::NUM_BLOCKS; k++) begin
			sz = (k == wfba_pkg::NUM_BLOCKS - 1) ? 16'hFFFF :
				(k == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
			send_item(mk(wfba_pkg::MODE_LOAD, 5'(k), sz));
		end
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'd0));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'hFFFF));
		send_item(mk(wfba_pkg::MODE_ALLOC, 5'd0, 16'd0));
	endtask

	// random loads and allocates across several block counts
	task automatic test_random_traffic();
		logic [5:0]     counts [7];
		wfba_pkg::req_t it;
		int             lim;
		int             k;
		logic [15:0]    sz;
		counts = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd33,
			6'($urandom_range(2, 31)), 6'($urandom_range(0, 63))};
		for (int p = 0; p < 7; p++) begin
			write_count(counts[p]);
			idle_on = (p % 2 == 0);
			lim = (search_count > wfba_pkg::NUM_BLOCKS) ? wfba_pkg::NUM_BLOCKS :
				int'(search_count);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				it.block_index = 5'($urandom_range(0, 31));
				if ($urandom_range(0, 99) < 45) begin
					// load, mostly into the searched range
					it.mode = wfba_pkg::MODE_LOAD;
					if (lim > 0 && $urandom_range(0, 3) != 0)
						it.block_index = 5'($urandom_range(0, lim - 1));
					case ($urandom_range(0, 5))
						0:       it.amount = 16'hFFFF;
						1, 2:    it.amount = 16'($urandom_range(0, 255));
						default: it.amount = 16'($urandom_range(0, 65535));
					endcase
				end else begin
					// allocate, mostly sized against a real partition
					it.mode = wfba_pkg::MODE_ALLOC;
					case ($urandom_range(0, 9))
						0:       it.amount = 16'd0;
						1:       it.amount = 16'hFFFF;
						2, 3:    it.amount = 16'($urandom_range(0, 65535));
						default: begin
							if (lim > 0) begin
								k  = $urandom_range(0, lim - 1);
								sz = part_size[k];
								it.amount = sz - (sz >> $urandom_range(1, 16));
							end else begin
								it.amount = 16'($urandom_range(0, 65535));
							end
						end
					endcase
				end
				send_item(it);
			end
		end
	endtask

	// result check against the oldest expectation
	always @(posedge clk) begin
		wfba_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				$error("result transfer with no allocate pending");
				fail_count++;
			end else begin
				want = pending_grants.pop_front();
				if (result.allocated !== want.allocated) begin
					$error("allocated: expected %0d, got %0d", want.allocated, result.allocated);
					fail_count++;
				end
				if (result.chosen_block !== want.chosen_block) begin
					$error("chosen_block: expected %0d, got %0d",
						want.chosen_block, result.chosen_block);
					fail_count++;
				end
				if (result.chosen_block_size !== want.chosen_block_size) begin
					$error("chosen_block_size: expected %0d, got %0d",
						want.chosen_block_size, result.chosen_block_size);
					fail_count++;
				end
				if (result.leftover !== want.leftover) begin
					$error("leftover: expected %0d, got %0d", want.leftover, result.leftover);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// test sequence
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tie_and_reload();
		test_zero_count();
		test_single_partition();
		test_full_table_saturated();
		test_random_traffic();
		start <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/wfba_pkg.sv
hdl/wfba_ctrl.sv
hdl/wfba_datapath.sv
hdl/worst_fit_block_allocator.sv
tb/worst_fit_block_allocator_tb.sv
